// ===== design/vths_pkg.sv =====
// ----------------------------------------------------------------------------
// vths_pkg: shared types and constants
// Grid geometry, function codes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package vths_pkg;
    localparam int ROWS = 24;
    localparam int COLS = 12;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int DEPTH = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] FUNC_HIT   = 2'd0;
    localparam logic [1:0] FUNC_EVAL  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] REG_HIT_CUT = 2'd0;
    localparam logic [1:0] REG_VETO    = 2'd1;
    localparam logic [1:0] REG_SAT     = 2'd2;

    // stored entry: amp_p, adc_p, tdc, sat
    typedef struct packed {
        logic signed [12:0] amp_p;
        logic signed [17:0] adc_p;
        logic               tdc;
        logic               sat;
    } entry_t;

    // read slot: which neighbour is being fetched
    localparam logic [2:0] SL_UP2 = 3'd0;
    localparam logic [2:0] SL_UP1 = 3'd1;
    localparam logic [2:0] SL_DN1 = 3'd2;
    localparam logic [2:0] SL_DN2 = 3'd3;
    localparam logic [2:0] SL_LEFT  = 3'd4;
    localparam logic [2:0] SL_RIGHT = 3'd5;
    localparam logic [2:0] SL_SELF  = 3'd6;

    typedef struct packed {
        logic             wr_en;      // write hit / clear word
        logic             clr;        // write zero entry
        logic [ADDR_W-1:0] clr_addr;
        logic             load;       // latch input item
        logic             rd_en;
        logic [2:0]       rd_slot;    // slot being issued
        logic [COL_W-1:0] col;
        logic             cap_en;     // capture data of previous issue
        logic [2:0]       cap_slot;
        logic             decide;     // form result into output reg
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       hit_ok;
        logic       eval_ok;
    } status_t;
endpackage

// ===== design/vths_datapath.sv =====
// ----------------------------------------------------------------------------
// vths_datapath: grid store and selection logic
// Single-port store read one entry a cycle; neighbour flags are collected
// into registers and the decision is formed after the last capture.
// ----------------------------------------------------------------------------
module vths_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vths_pkg::cmd_t        cmd,
    output vths_pkg::status_t     status,
    input  logic [1:0]            in_func,
    input  logic signed [5:0]     in_row,
    input  logic signed [4:0]     in_col,
    input  logic [11:0]           in_amp_raw,
    input  logic signed [12:0]    in_amp_p,
    input  logic signed [17:0]    in_adc_p,
    input  logic                  in_tdc,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [12:0]           cfg_data,
    output logic [73:0]           res_data,
    output logic                  res_last
);
    import vths_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_reg;

    logic signed [12:0] cut_reg, veto_reg;
    logic [11:0]        sat_reg;
    logic [1:0]  func_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    entry_t      hit_reg;
    logic        hit_ok_reg, eval_ok_reg;
    logic [31:0] total_reg, total_next;
    logic        up2_reg, up1_reg, dn1_reg, dn2_reg, lq_reg, rq_reg;
    logic [73:0] res_reg;
    logic        last_reg;

    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [ROW_W:0]    rd_row;   // may go out of range, then unused
    logic [ROW_W-1:0]  rr;
    logic [COL_W:0]    rd_col;
    logic [COL_W-1:0]  rc;
    entry_t wr_data;
    logic   ok, track, hit_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_reg <= 13'sd5;
            veto_reg <= 13'sd6;
            sat_reg <= 12'd4094;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_HIT_CUT: cut_reg <= cfg_data;
                REG_VETO:    veto_reg <= cfg_data;
                REG_SAT:     sat_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            row_reg <= in_row[ROW_W-1:0];
            col_reg <= in_col[COL_W-1:0];
            hit_reg.amp_p <= in_amp_p;
            hit_reg.adc_p <= in_adc_p;
            hit_reg.tdc <= in_tdc;
            hit_reg.sat <= (in_amp_raw > sat_reg);
            hit_ok_reg <= !in_row[5] && (in_row < 6'(ROWS))
                       && !in_col[4] && (in_col < 5'(COLS));
            eval_ok_reg <= !in_row[5] && (in_row < 6'(ROWS));
        end
    end

    assign status = '{func: func_reg, hit_ok: hit_ok_reg, eval_ok: eval_ok_reg};

    always_comb begin
        wr_addr = ADDR_W'(row_reg * COLS + col_reg);
        wr_data = hit_reg;
        if (cmd.clr) begin
            wr_addr = cmd.clr_addr;
            wr_data = '0;
        end
        rd_row = {1'b0, row_reg};
        rd_col = {1'b0, cmd.col};
        case (cmd.rd_slot)
            SL_UP2:   rd_row = {1'b0, row_reg} - 2'd2;
            SL_UP1:   rd_row = {1'b0, row_reg} - 1'd1;
            SL_DN1:   rd_row = {1'b0, row_reg} + 1'd1;
            SL_DN2:   rd_row = {1'b0, row_reg} + 2'd2;
            SL_LEFT:  rd_col = {1'b0, cmd.col} - 1'd1;
            SL_RIGHT: rd_col = {1'b0, cmd.col} + 1'd1;
            default: ;
        endcase
        rr = rd_row[ROW_W-1:0];
        rc = rd_col[COL_W-1:0];
        rd_addr = ADDR_W'(rr * COLS + rc);
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_en) rd_reg <= mem[rd_addr];
    end

    // capture neighbour flags; out-of-grid neighbours masked here
    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            case (cmd.cap_slot)
                SL_UP2:   up2_reg <= (row_reg >= ROW_W'(2)) && (rd_reg.amp_p > cut_reg);
                SL_UP1:   up1_reg <= (row_reg >= ROW_W'(1)) && (rd_reg.amp_p > cut_reg);
                SL_DN1:   dn1_reg <= ({1'b0, row_reg} + 1'd1 < (ROW_W+1)'(ROWS))
                                     && (rd_reg.amp_p > cut_reg);
                SL_DN2:   dn2_reg <= ({1'b0, row_reg} + 2'd2 < (ROW_W+1)'(ROWS))
                                     && (rd_reg.amp_p > cut_reg);
                SL_LEFT:  lq_reg <= (cmd.col == '0) || (rd_reg.amp_p < veto_reg);
                SL_RIGHT: rq_reg <= (cmd.col == COL_W'(COLS - 1))
                                    || (rd_reg.amp_p < veto_reg);
                default: ;
            endcase
        end
    end

    always_comb begin
        hit_c = rd_reg.amp_p > cut_reg;
        track = (up2_reg && up1_reg) || (up1_reg && dn1_reg) || (dn1_reg && dn2_reg);
        ok = hit_c && !rd_reg.sat && track && lq_reg && rq_reg;
        total_next = total_reg + 32'(ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) total_reg <= '0;
        else if (cmd.decide) total_reg <= total_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_reg <= {total_next, rd_reg.adc_p, rd_reg.amp_p, rd_reg.tdc, ok,
                        4'(cmd.col), 5'(row_reg)};
            last_reg <= cmd.last;
        end
    end

    assign res_data = res_reg;
    assign res_last = last_reg;
endmodule

// ===== design/vths_ctrl.sv =====
// ----------------------------------------------------------------------------
// vths_ctrl: sequencer
// Runs hit writes, the clearing sweep and the seven-read scan per column.
// ----------------------------------------------------------------------------
module vths_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  vths_pkg::status_t     status,
    output vths_pkg::cmd_t        cmd
);
    import vths_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        slot_next = slot_reg;
        col_next = col_reg;
        clr_next = clr_reg;
        mv_next = mv_reg;
        cmd = '0;
        cmd.col = col_reg;
        cmd.clr_addr = clr_reg;
        cmd.rd_slot = slot_reg;
        cmd.cap_slot = slot_reg - 3'd1;
        s_ready = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (status.func)
                    FUNC_HIT: begin
                        cmd.wr_en = status.hit_ok;
                        state_next = ST_IDLE;
                    end
                    FUNC_CLEAR: begin
                        clr_next = '0;
                        state_next = ST_CLR;
                    end
                    FUNC_EVAL: begin
                        col_next = '0;
                        slot_next = SL_UP2;
                        state_next = status.eval_ok ? ST_READ : ST_IDLE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_CLR: begin
                cmd.wr_en = 1'b1;
                cmd.clr = 1'b1;
                clr_next = clr_reg + 1'd1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                cmd.cap_en = (slot_reg != SL_UP2);
                slot_next = slot_reg + 3'd1;
                if (slot_reg == SL_SELF) state_next = ST_DEC;
            end
            ST_DEC: begin
                // wait for the output register to free up
                if (!mv_next) begin
                    cmd.decide = 1'b1;
                    cmd.last = (col_reg == COL_W'(COLS - 1));
                    mv_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (col_reg == COL_W'(COLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    col_next = col_reg + 1'd1;
                    slot_next = SL_UP2;
                    state_next = ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // reset starts with a clearing sweep of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            mv_reg <= 1'b0;
            slot_reg <= '0;
            col_reg <= '0;
            clr_reg <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            slot_reg <= slot_next;
            col_reg <= col_next;
            clr_reg <= clr_next;
        end
    end

    assign m_valid = mv_reg;
endmodule

// ===== design/vertical_track_hit_selector_core.sv =====
// Hit write: latch, then write in the dispatch state. Clear: a sweep zeroes all
// 288 entries. Evaluate: per column, seven single-port store reads, then decide; 12 beats out.
// One item in flight; a result beat waits in the output register while the
// next column is read. Reset (aresetn, synchronous) restores registers and
// count, then a sweep zeroes the grid store with the input held off.
// ----------------------------------------------------------------------------
// vertical_track_hit_selector_core: top level
// Vertical cosmic track selection on a 24 x 12 channel grid.
// ----------------------------------------------------------------------------
module vertical_track_hit_selector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[5:0], col[10:6], amp_raw[22:11], amp_p[35:23],
    // adc_p[53:36], tdc_present[54]
    input  logic [55:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_row[4:0], out_col[8:5], accepted[9], out_tdc_present[10],
    // out_amp_p[23:11], out_adc_p[41:24], accepted_total[73:42]
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import vths_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [73:0] res;

    vths_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .status(status), .cmd(cmd)
    );

    vths_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_func(s_axis_tuser),
        .in_row(s_axis_tdata[5:0]),
        .in_col(s_axis_tdata[10:6]),
        .in_amp_raw(s_axis_tdata[22:11]),
        .in_amp_p(s_axis_tdata[35:23]),
        .in_adc_p(s_axis_tdata[53:36]),
        .in_tdc(s_axis_tdata[54]),
        .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata),
        .res_data(res), .res_last(m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, res};
endmodule
